// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; take in with a bare include before the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked at every clock edge, reset included
`define ASSERT_CLKD_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- rtl/rycq_pkg.sv -----
// shared types and constants of the rgb to ycbcr 4:2:0 quad converter
// no dependencies; used by the lane, merge and top level modules
`default_nettype none

package rycq_pkg;

    // lane and pipeline geometry
    localparam int NUM_LANES  = 4;
    localparam int NUM_STAGES = 6;

    // field and datapath widths
    localparam int PIX_W       = 8;
    localparam int FRAME_H_W   = 12;
    localparam int COEF_W      = 16;
    localparam int Y_W         = 24;
    localparam int DIFF_W      = 25;
    localparam int LUMA_PROD_W = 40;
    localparam int LUMA_SUM_W  = 41;
    localparam int TERM_W      = 41;
    localparam int SUM_W       = 43;
    localparam int SPLIT_W     = 22;
    localparam int LO_PROD_W   = 36;
    localparam int HI_PROD_W   = 35;
    localparam int TOTAL_W     = 58;
    localparam int CSCALE_W    = 14;

    // matrix choice and register reset
    localparam logic [FRAME_H_W-1:0] SD_LINE_LIMIT      = 12'd576;
    localparam logic [FRAME_H_W-1:0] FRAME_HEIGHT_RESET = 12'd1080;

    typedef struct packed {
        logic [COEF_W-1:0] kr;
        logic [COEF_W-1:0] kg;
        logic [COEF_W-1:0] kb;
        logic [COEF_W-1:0] cb_scale;
        logic [COEF_W-1:0] cr_scale;
    } t_coef_set;

    // coefficients in q16
    localparam t_coef_set SD_MATRIX = '{kr: 16'd19595, kg: 16'd38470, kb: 16'd7471,
                                        cb_scale: 16'd36984, cr_scale: 16'd46745};
    localparam t_coef_set HD_MATRIX = '{kr: 16'd13933, kg: 16'd46871, kb: 16'd4732,
                                        cb_scale: 16'd35318, cr_scale: 16'd41615};

    localparam logic [COEF_W-1:0]   LUMA_SCALE   = 16'd56284;
    localparam logic [CSCALE_W-1:0] CHROMA_SCALE = 14'd14392;

    // 16.5 in q32 and 128.5 in q48
    localparam logic [LUMA_SUM_W-1:0] LUMA_OFFSET   = LUMA_SUM_W'(33) << 31;
    localparam logic [TOTAL_W-1:0]    CHROMA_OFFSET = TOTAL_W'(257) << 47;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pixel;

    // stage load enables for the lanes plus the matrix choice
    typedef struct packed {
        logic load_s1;
        logic load_s2;
        logic load_s3;
        logic hd_mode;
    } t_lane_ctrl;

    // stage load enables for the merge stages
    typedef struct packed {
        logic load_s4;
        logic load_s5;
        logic load_s6;
    } t_merge_ctrl;

endpackage

`default_nettype wire

// ----- rtl/rgb_to_ycbcr420_quad.sv -----
// top level of the rgb to ycbcr 4:2:0 quad converter: ports, config, pipeline control
// depends on rycq_pkg, rycq_lane and rycq_merge
`default_nettype none

// Converts one 2x2 quad of full-range 8-bit RGB pixels per item into four TV-range
// luma bytes and one averaged Cb/Cr pair. A frame height of 576 lines or fewer
// selects the SD (170M) matrix, anything larger selects BT.709; write the height
// only while the block is idle. Throughput is one quad per clock while the output is
// not stalled. The item passes six register stages: three in each of the four pixel
// lanes (matrix, scale, weighted differences) and three in the merge (chroma sum,
// split 43x14 chroma product, recombine and round); the last merge stage drives
// the outputs and o_valid. Stall from the output ripples back through the stages,
// and an empty stage keeps accepting, so bubbles are squeezed out while the output
// is held.
module rgb_to_ycbcr420_quad (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_wr_en,
    input  logic [rycq_pkg::FRAME_H_W-1:0]     i_cfg_wr_data,
    // input channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [rycq_pkg::PIX_W-1:0]         i_top_left_red,
    input  logic [rycq_pkg::PIX_W-1:0]         i_top_left_green,
    input  logic [rycq_pkg::PIX_W-1:0]         i_top_left_blue,
    input  logic [rycq_pkg::PIX_W-1:0]         i_top_right_red,
    input  logic [rycq_pkg::PIX_W-1:0]         i_top_right_green,
    input  logic [rycq_pkg::PIX_W-1:0]         i_top_right_blue,
    input  logic [rycq_pkg::PIX_W-1:0]         i_bottom_left_red,
    input  logic [rycq_pkg::PIX_W-1:0]         i_bottom_left_green,
    input  logic [rycq_pkg::PIX_W-1:0]         i_bottom_left_blue,
    input  logic [rycq_pkg::PIX_W-1:0]         i_bottom_right_red,
    input  logic [rycq_pkg::PIX_W-1:0]         i_bottom_right_green,
    input  logic [rycq_pkg::PIX_W-1:0]         i_bottom_right_blue,
    // output channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [rycq_pkg::PIX_W-1:0]         o_luma_top_left,
    output logic [rycq_pkg::PIX_W-1:0]         o_luma_top_right,
    output logic [rycq_pkg::PIX_W-1:0]         o_luma_bottom_left,
    output logic [rycq_pkg::PIX_W-1:0]         o_luma_bottom_right,
    output logic [rycq_pkg::PIX_W-1:0]         o_chroma_blue,
    output logic [rycq_pkg::PIX_W-1:0]         o_chroma_red
);

    logic [rycq_pkg::FRAME_H_W-1:0]  r_frame_height;
    logic [rycq_pkg::NUM_STAGES-1:0] r_vld;
    logic [rycq_pkg::NUM_STAGES:0]   stage_ready;

    rycq_pkg::t_pixel      pixels [rycq_pkg::NUM_LANES];
    rycq_pkg::t_lane_ctrl  lane_ctrl;
    rycq_pkg::t_merge_ctrl merge_ctrl;

    logic [rycq_pkg::PIX_W-1:0]         lane_luma [rycq_pkg::NUM_LANES];
    logic signed [rycq_pkg::TERM_W-1:0] lane_cb   [rycq_pkg::NUM_LANES];
    logic signed [rycq_pkg::TERM_W-1:0] lane_cr   [rycq_pkg::NUM_LANES];
    logic [rycq_pkg::PIX_W-1:0]         out_luma  [rycq_pkg::NUM_LANES];

    // frame height register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_height <= rycq_pkg::FRAME_HEIGHT_RESET;
        end else if (i_cfg_wr_en) begin
            r_frame_height <= i_cfg_wr_data;
        end
    end

    // a stage may load when it is empty or the one after it moves
    always_comb begin
        stage_ready[rycq_pkg::NUM_STAGES] = !i_stall;
        for (int k = rycq_pkg::NUM_STAGES - 1; k >= 0; k--) begin
            stage_ready[k] = !r_vld[k] || stage_ready[k+1];
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_ready[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < rycq_pkg::NUM_STAGES; k++) begin
                if (stage_ready[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !stage_ready[0];
    assign o_valid = r_vld[rycq_pkg::NUM_STAGES-1];

    // stage enables
    assign lane_ctrl.load_s1  = stage_ready[0];
    assign lane_ctrl.load_s2  = stage_ready[1];
    assign lane_ctrl.load_s3  = stage_ready[2];
    assign lane_ctrl.hd_mode  = r_frame_height > rycq_pkg::SD_LINE_LIMIT;
    assign merge_ctrl.load_s4 = stage_ready[3];
    assign merge_ctrl.load_s5 = stage_ready[4];
    assign merge_ctrl.load_s6 = stage_ready[5];

    // quad pixels in raster order
    assign pixels[0] = '{red: i_top_left_red, green: i_top_left_green,
                         blue: i_top_left_blue};
    assign pixels[1] = '{red: i_top_right_red, green: i_top_right_green,
                         blue: i_top_right_blue};
    assign pixels[2] = '{red: i_bottom_left_red, green: i_bottom_left_green,
                         blue: i_bottom_left_blue};
    assign pixels[3] = '{red: i_bottom_right_red, green: i_bottom_right_green,
                         blue: i_bottom_right_blue};

    // per-pixel lanes
    for (genvar g = 0; g < rycq_pkg::NUM_LANES; g++) begin : g_lane
        rycq_lane u_lane (
            .i_clk     (i_clk),
            .i_ctrl    (lane_ctrl),
            .i_pixel   (pixels[g]),
            .o_luma    (lane_luma[g]),
            .o_cb_term (lane_cb[g]),
            .o_cr_term (lane_cr[g])
        );
    end

    // chroma merge and output registers
    rycq_merge u_merge (
        .i_clk         (i_clk),
        .i_ctrl        (merge_ctrl),
        .i_luma        (lane_luma),
        .i_cb_term     (lane_cb),
        .i_cr_term     (lane_cr),
        .o_luma        (out_luma),
        .o_chroma_blue (o_chroma_blue),
        .o_chroma_red  (o_chroma_red)
    );

    assign o_luma_top_left     = out_luma[0];
    assign o_luma_top_right    = out_luma[1];
    assign o_luma_bottom_left  = out_luma[2];
    assign o_luma_bottom_right = out_luma[3];

endmodule

`default_nettype wire

// ----- rtl/rycq_lane.sv -----
// one per-pixel lane: matrix, luma scaling and weighted chroma differences
// depends on rycq_pkg
`default_nettype none

module rycq_lane (
    input  logic                             i_clk,
    input  rycq_pkg::t_lane_ctrl             i_ctrl,
    input  rycq_pkg::t_pixel                 i_pixel,
    output logic [rycq_pkg::PIX_W-1:0]       o_luma,
    output logic signed [rycq_pkg::TERM_W-1:0] o_cb_term,
    output logic signed [rycq_pkg::TERM_W-1:0] o_cr_term
);

    rycq_pkg::t_coef_set coef;

    logic [rycq_pkg::Y_W-1:0]   n_y;
    logic [rycq_pkg::Y_W-1:0]   r_y;
    logic [rycq_pkg::PIX_W-1:0] r_red;
    logic [rycq_pkg::PIX_W-1:0] r_blue;

    logic [rycq_pkg::LUMA_PROD_W-1:0]   n_luma_prod;
    logic [rycq_pkg::LUMA_PROD_W-1:0]   r_luma_prod;
    logic signed [rycq_pkg::DIFF_W-1:0] n_cb_diff;
    logic signed [rycq_pkg::DIFF_W-1:0] n_cr_diff;
    logic signed [rycq_pkg::DIFF_W-1:0] r_cb_diff;
    logic signed [rycq_pkg::DIFF_W-1:0] r_cr_diff;

    logic [rycq_pkg::LUMA_SUM_W-1:0]    luma_sum;
    logic [rycq_pkg::PIX_W-1:0]         n_luma;
    logic signed [rycq_pkg::TERM_W-1:0] cb_scale_s;
    logic signed [rycq_pkg::TERM_W-1:0] cr_scale_s;
    logic signed [rycq_pkg::TERM_W-1:0] n_cb_term;
    logic signed [rycq_pkg::TERM_W-1:0] n_cr_term;
    logic [rycq_pkg::PIX_W-1:0]         r_luma;
    logic signed [rycq_pkg::TERM_W-1:0] r_cb_term;
    logic signed [rycq_pkg::TERM_W-1:0] r_cr_term;

    assign coef = i_ctrl.hd_mode ? rycq_pkg::HD_MATRIX : rycq_pkg::SD_MATRIX;

    // stage 1: luma in q16
    assign n_y = rycq_pkg::Y_W'(i_pixel.red)   * rycq_pkg::Y_W'(coef.kr)
               + rycq_pkg::Y_W'(i_pixel.green) * rycq_pkg::Y_W'(coef.kg)
               + rycq_pkg::Y_W'(i_pixel.blue)  * rycq_pkg::Y_W'(coef.kb);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_s1) begin
            r_y    <= n_y;
            r_red  <= i_pixel.red;
            r_blue <= i_pixel.blue;
        end
    end

    // stage 2: luma scale product and color differences
    assign n_luma_prod = rycq_pkg::LUMA_PROD_W'(r_y)
                       * rycq_pkg::LUMA_PROD_W'(rycq_pkg::LUMA_SCALE);
    assign n_cb_diff   = $signed({1'b0, r_blue, 16'd0}) - $signed({1'b0, r_y});
    assign n_cr_diff   = $signed({1'b0, r_red, 16'd0}) - $signed({1'b0, r_y});

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_s2) begin
            r_luma_prod <= n_luma_prod;
            r_cb_diff   <= n_cb_diff;
            r_cr_diff   <= n_cr_diff;
        end
    end

    // stage 3: luma offset, truncation and clamp; weighted differences
    assign luma_sum = rycq_pkg::LUMA_SUM_W'(r_luma_prod) + rycq_pkg::LUMA_OFFSET;
    assign n_luma   = luma_sum[rycq_pkg::LUMA_SUM_W-1] ? '1 : luma_sum[39:32];

    assign cb_scale_s = rycq_pkg::TERM_W'(coef.cb_scale);
    assign cr_scale_s = rycq_pkg::TERM_W'(coef.cr_scale);
    assign n_cb_term  = rycq_pkg::TERM_W'(r_cb_diff) * cb_scale_s;
    assign n_cr_term  = rycq_pkg::TERM_W'(r_cr_diff) * cr_scale_s;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_s3) begin
            r_luma    <= n_luma;
            r_cb_term <= n_cb_term;
            r_cr_term <= n_cr_term;
        end
    end

    assign o_luma    = r_luma;
    assign o_cb_term = r_cb_term;
    assign o_cr_term = r_cr_term;

endmodule

`default_nettype wire

// ----- rtl/rycq_merge.sv -----
// merge stages: sums the four lanes' chroma terms, scales and rounds them, and carries the luma bytes along
// depends on rycq_pkg; fed by four rycq_lane instances
`default_nettype none

module rycq_merge (
    input  logic                               i_clk,
    input  rycq_pkg::t_merge_ctrl              i_ctrl,
    input  logic [rycq_pkg::PIX_W-1:0]         i_luma [rycq_pkg::NUM_LANES],
    input  logic signed [rycq_pkg::TERM_W-1:0] i_cb_term [rycq_pkg::NUM_LANES],
    input  logic signed [rycq_pkg::TERM_W-1:0] i_cr_term [rycq_pkg::NUM_LANES],
    output logic [rycq_pkg::PIX_W-1:0]         o_luma [rycq_pkg::NUM_LANES],
    output logic [rycq_pkg::PIX_W-1:0]         o_chroma_blue,
    output logic [rycq_pkg::PIX_W-1:0]         o_chroma_red
);

    localparam logic signed [rycq_pkg::HI_PROD_W-1:0] ScaleHi =
        rycq_pkg::HI_PROD_W'(rycq_pkg::CHROMA_SCALE);

    // offset, truncate and clamp of the recombined chroma product
    function automatic logic [rycq_pkg::PIX_W-1:0] chroma_final(
        input logic signed [rycq_pkg::HI_PROD_W-1:0] hi,
        input logic [rycq_pkg::LO_PROD_W-1:0]        lo
    );
        logic [rycq_pkg::TOTAL_W-1:0] total;
        total = (rycq_pkg::TOTAL_W'(hi) << rycq_pkg::SPLIT_W)
              + rycq_pkg::TOTAL_W'(lo) + rycq_pkg::CHROMA_OFFSET;
        if (total[rycq_pkg::TOTAL_W-1]) begin
            return '0;
        end else if (total[56]) begin
            return '1;
        end else begin
            return total[55:48];
        end
    endfunction

    logic [rycq_pkg::PIX_W-1:0] r_luma_s4 [rycq_pkg::NUM_LANES];
    logic [rycq_pkg::PIX_W-1:0] r_luma_s5 [rycq_pkg::NUM_LANES];
    logic [rycq_pkg::PIX_W-1:0] r_luma_s6 [rycq_pkg::NUM_LANES];

    logic signed [rycq_pkg::SUM_W-1:0] n_cb_sum;
    logic signed [rycq_pkg::SUM_W-1:0] n_cr_sum;
    logic signed [rycq_pkg::SUM_W-1:0] r_cb_sum;
    logic signed [rycq_pkg::SUM_W-1:0] r_cr_sum;

    logic signed [rycq_pkg::HI_PROD_W-1:0] cb_hi_ext;
    logic signed [rycq_pkg::HI_PROD_W-1:0] cr_hi_ext;
    logic signed [rycq_pkg::HI_PROD_W-1:0] r_cb_hi;
    logic signed [rycq_pkg::HI_PROD_W-1:0] r_cr_hi;
    logic [rycq_pkg::LO_PROD_W-1:0]        r_cb_lo;
    logic [rycq_pkg::LO_PROD_W-1:0]        r_cr_lo;

    logic [rycq_pkg::PIX_W-1:0] r_chroma_blue;
    logic [rycq_pkg::PIX_W-1:0] r_chroma_red;

    // stage 4: sum of the four lane terms
    assign n_cb_sum = rycq_pkg::SUM_W'(i_cb_term[0]) + rycq_pkg::SUM_W'(i_cb_term[1])
                    + rycq_pkg::SUM_W'(i_cb_term[2]) + rycq_pkg::SUM_W'(i_cb_term[3]);
    assign n_cr_sum = rycq_pkg::SUM_W'(i_cr_term[0]) + rycq_pkg::SUM_W'(i_cr_term[1])
                    + rycq_pkg::SUM_W'(i_cr_term[2]) + rycq_pkg::SUM_W'(i_cr_term[3]);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_s4) begin
            r_cb_sum  <= n_cb_sum;
            r_cr_sum  <= n_cr_sum;
            r_luma_s4 <= i_luma;
        end
    end

    // stage 5: chroma scale as two partial products, low half unsigned
    assign cb_hi_ext = rycq_pkg::HI_PROD_W'($signed(r_cb_sum[rycq_pkg::SUM_W-1:rycq_pkg::SPLIT_W]));
    assign cr_hi_ext = rycq_pkg::HI_PROD_W'($signed(r_cr_sum[rycq_pkg::SUM_W-1:rycq_pkg::SPLIT_W]));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_s5) begin
            r_cb_hi   <= cb_hi_ext * ScaleHi;
            r_cr_hi   <= cr_hi_ext * ScaleHi;
            r_cb_lo   <= rycq_pkg::LO_PROD_W'(r_cb_sum[rycq_pkg::SPLIT_W-1:0])
                       * rycq_pkg::LO_PROD_W'(rycq_pkg::CHROMA_SCALE);
            r_cr_lo   <= rycq_pkg::LO_PROD_W'(r_cr_sum[rycq_pkg::SPLIT_W-1:0])
                       * rycq_pkg::LO_PROD_W'(rycq_pkg::CHROMA_SCALE);
            r_luma_s5 <= r_luma_s4;
        end
    end

    // stage 6: recombine, offset and output register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_s6) begin
            r_chroma_blue <= chroma_final(r_cb_hi, r_cb_lo);
            r_chroma_red  <= chroma_final(r_cr_hi, r_cr_lo);
            r_luma_s6     <= r_luma_s5;
        end
    end

    assign o_luma        = r_luma_s6;
    assign o_chroma_blue = r_chroma_blue;
    assign o_chroma_red  = r_chroma_red;

endmodule

`default_nettype wire

// ----- rtl/rycq_checker.sv -----
// port-level checks of the quad converter and the bind that attaches them
// depends on assert_macros.svh and the rgb_to_ycbcr420_quad top level
`default_nettype none

`include "assert_macros.svh"

module rycq_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_luma_top_left,
    input  logic [7:0] i_luma_top_right,
    input  logic [7:0] i_luma_bottom_left,
    input  logic [7:0] i_luma_bottom_right,
    input  logic [7:0] i_chroma_blue,
    input  logic [7:0] i_chroma_red
);

    logic        out_held;
    logic [47:0] out_payload;
    logic        luma_in_range;
    logic        chroma_in_range;

    // output item held by the receiver, its payload and range flags
    assign out_held    = i_out_valid && i_out_stall;
    assign out_payload = {i_luma_top_left, i_luma_top_right, i_luma_bottom_left,
                          i_luma_bottom_right, i_chroma_blue, i_chroma_red};

    assign luma_in_range = i_luma_top_left >= 8'd16 && i_luma_top_left <= 8'd235
                        && i_luma_top_right >= 8'd16 && i_luma_top_right <= 8'd235
                        && i_luma_bottom_left >= 8'd16 && i_luma_bottom_left <= 8'd235
                        && i_luma_bottom_right >= 8'd16 && i_luma_bottom_right <= 8'd235;

    assign chroma_in_range = i_chroma_blue >= 8'd16 && i_chroma_blue <= 8'd240
                          && i_chroma_red >= 8'd16 && i_chroma_red <= 8'd240;

    // reset empties the pipeline
    `ASSERT_CLKD_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !i_out_valid, "item valid after reset")

    // a stalled item stays offered
    `ASSERT_CLKD(a_stall_holds_valid, i_clk, i_rst_n, out_held |=> i_out_valid, "stalled item dropped")

    // a stalled item keeps its payload
    `ASSERT_CLKD(a_hold_payload, i_clk, i_rst_n, out_held |=> $stable(out_payload), "payload changed")

    // luma stays in tv range
    `ASSERT_CLKD(a_luma_range, i_clk, i_rst_n, i_out_valid |-> luma_in_range, "luma outside tv range")

    // chroma stays in tv range
    `ASSERT_CLKD(a_chroma_range, i_clk, i_rst_n, i_out_valid |-> chroma_in_range, "chroma out of range")

endmodule

bind rgb_to_ycbcr420_quad rycq_checker u_rycq_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_out_valid         (o_valid),
    .i_out_stall         (i_stall),
    .i_luma_top_left     (o_luma_top_left),
    .i_luma_top_right    (o_luma_top_right),
    .i_luma_bottom_left  (o_luma_bottom_left),
    .i_luma_bottom_right (o_luma_bottom_right),
    .i_chroma_blue       (o_chroma_blue),
    .i_chroma_red        (o_chroma_red)
);

`default_nettype wire

// ----- tb/rgb_to_ycbcr420_quad_tb.sv -----
`timescale 1ns / 1ps
// testbench for rgb_to_ycbcr420_quad: directed and random 2x2 quads under both matrices
// depends on rycq_pkg and the rgb_to_ycbcr420_quad rtl; expected bytes come from a
// fixed-point conversion kept in this file, checked in order against every output item
module rgb_to_ycbcr420_quad_tb;

    // quad of pixels, index 0 top left, 1 top right, 2 bottom left, 3 bottom right
    typedef rycq_pkg::t_pixel [0:3] t_rgb_quad;

    typedef struct packed {
        logic [7:0] luma_tl;
        logic [7:0] luma_tr;
        logic [7:0] luma_bl;
        logic [7:0] luma_br;
        logic [7:0] chroma_b;
        logic [7:0] chroma_r;
    } t_ycc_quad;

    typedef enum logic { MATRIX_SD, MATRIX_HD } t_matrix_sel;

    // matrix choice and register reset
    localparam logic [11:0] SD_MAX_LINES    = 12'd576;
    localparam logic [11:0] HEIGHT_AT_RESET = 12'd1080;

    // q16 coefficients
    localparam longint SD_KR = 19595, SD_KG = 38470, SD_KB = 7471;
    localparam longint SD_CB = 36984, SD_CR = 46745;
    localparam longint HD_KR = 13933, HD_KG = 46871, HD_KB = 4732;
    localparam longint HD_CB = 35318, HD_CR = 41615;
    localparam longint Y_TO_TV    = 56284;
    localparam longint CHROMA_AVG = 14392;

    // 16.5 in q32, 128.5 in q48
    localparam longint LUMA_BIAS   = longint'(33) << 31;
    localparam longint CHROMA_BIAS = longint'(257) << 47;

    // cycles to let the pipeline settle before a register write or the end
    localparam int SETTLE_CYCLES   = 12;
    localparam int MAX_PRINTED     = 30;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [11:0] i_cfg_wr_data = 12'd0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_top_left_red = 8'd0;
    logic [7:0]  i_top_left_green = 8'd0;
    logic [7:0]  i_top_left_blue = 8'd0;
    logic [7:0]  i_top_right_red = 8'd0;
    logic [7:0]  i_top_right_green = 8'd0;
    logic [7:0]  i_top_right_blue = 8'd0;
    logic [7:0]  i_bottom_left_red = 8'd0;
    logic [7:0]  i_bottom_left_green = 8'd0;
    logic [7:0]  i_bottom_left_blue = 8'd0;
    logic [7:0]  i_bottom_right_red = 8'd0;
    logic [7:0]  i_bottom_right_green = 8'd0;
    logic [7:0]  i_bottom_right_blue = 8'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_luma_top_left;
    logic [7:0]  o_luma_top_right;
    logic [7:0]  o_luma_bottom_left;
    logic [7:0]  o_luma_bottom_right;
    logic [7:0]  o_chroma_blue;
    logic [7:0]  o_chroma_red;

    // checker state
    t_ycc_quad   pending_ycc[$];
    logic [11:0] model_height = HEIGHT_AT_RESET;
    int          mismatch_count = 0;
    int          results_seen = 0;

    // idling controls: gap and stall chances in percent, then stall run and hold-off counters
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          stall_run = 0;
    int          hold_left = 0;

    rgb_to_ycbcr420_quad dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_wr_en          (i_cfg_wr_en),
        .i_cfg_wr_data        (i_cfg_wr_data),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_top_left_red       (i_top_left_red),
        .i_top_left_green     (i_top_left_green),
        .i_top_left_blue      (i_top_left_blue),
        .i_top_right_red      (i_top_right_red),
        .i_top_right_green    (i_top_right_green),
        .i_top_right_blue     (i_top_right_blue),
        .i_bottom_left_red    (i_bottom_left_red),
        .i_bottom_left_green  (i_bottom_left_green),
        .i_bottom_left_blue   (i_bottom_left_blue),
        .i_bottom_right_red   (i_bottom_right_red),
        .i_bottom_right_green (i_bottom_right_green),
        .i_bottom_right_blue  (i_bottom_right_blue),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_luma_top_left      (o_luma_top_left),
        .o_luma_top_right     (o_luma_top_right),
        .o_luma_bottom_left   (o_luma_bottom_left),
        .o_luma_bottom_right  (o_luma_bottom_right),
        .o_chroma_blue        (o_chroma_blue),
        .o_chroma_red         (o_chroma_red)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // truncate a fixed-point value to a byte, clamped to 0..255
    function automatic logic [7:0] clamp_byte(input longint v, input int frac_bits);
        longint r;
        if (v < 0) return 8'd0;
        r = v >>> frac_bits;
        if (r > 255) return 8'hff;
        return r[7:0];
    endfunction

    // full-range rgb quad to tv-range luma and averaged chroma
    function automatic t_ycc_quad convert_quad(input t_rgb_quad q, input logic [11:0] height);
        longint      kr, kg, kb, cb_k, cr_k;
        longint      r, g, b, y;
        longint      usum, vsum;
        logic [3:0][7:0] luma;
        t_matrix_sel sel;
        t_ycc_quad   res;
        int          p;
        sel = (height <= SD_MAX_LINES) ? MATRIX_SD : MATRIX_HD;
        case (sel)
            MATRIX_SD: begin
                kr = SD_KR; kg = SD_KG; kb = SD_KB; cb_k = SD_CB; cr_k = SD_CR;
            end
            default: begin
                kr = HD_KR; kg = HD_KG; kb = HD_KB; cb_k = HD_CB; cr_k = HD_CR;
            end
        endcase
        usum = 0;
        vsum = 0;
        for (p = 0; p < 4; p++) begin
            r = longint'(q[p].red);
            g = longint'(q[p].green);
            b = longint'(q[p].blue);
            // y in q16, luma in q32, weighted differences in q32
            y = kr * r + kg * g + kb * b;
            luma[p] = clamp_byte(y * Y_TO_TV + LUMA_BIAS, 32);
            usum += (b * 65536 - y) * cb_k;
            vsum += (r * 65536 - y) * cr_k;
        end
        res.luma_tl  = luma[0];
        res.luma_tr  = luma[1];
        res.luma_bl  = luma[2];
        res.luma_br  = luma[3];
        res.chroma_b = clamp_byte(usum * CHROMA_AVG + CHROMA_BIAS, 48);
        res.chroma_r = clamp_byte(vsum * CHROMA_AVG + CHROMA_BIAS, 48);
        return res;
    endfunction

    function automatic rycq_pkg::t_pixel make_px(input int r, input int g, input int b);
        rycq_pkg::t_pixel px;
        px.red   = r[7:0];
        px.green = g[7:0];
        px.blue  = b[7:0];
        return px;
    endfunction

    function automatic t_rgb_quad flat_quad(input rycq_pkg::t_pixel px);
        return {px, px, px, px};
    endfunction

    // mostly uniform pixels, some at the channel extremes, some grey
    function automatic t_rgb_quad random_quad();
        t_rgb_quad q;
        int        p;
        int        v;
        for (p = 0; p < 4; p++) begin
            case ($urandom_range(9))
                0: q[p] = make_px($urandom_range(1) * 255, $urandom_range(1) * 255,
                                  $urandom_range(1) * 255);
                1: begin
                    v = $urandom_range(255);
                    q[p] = make_px(v, v, v);
                end
                default: q[p] = make_px($urandom_range(255), $urandom_range(255),
                                        $urandom_range(255));
            endcase
        end
        return q;
    endfunction

    // idle length: mostly short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch at result %0d: %s got %0d want %0d",
                     results_seen, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) report_mismatch(what, int'(got), int'(want));
    endtask

    // output side: compare each accepted item with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_ycc_quad want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_ycc.size() == 0) begin
                report_mismatch("output item with nothing pending", 0, 0);
            end else begin
                want = pending_ycc.pop_front();
                check_field("luma_top_left", o_luma_top_left, want.luma_tl);
                check_field("luma_top_right", o_luma_top_right, want.luma_tr);
                check_field("luma_bottom_left", o_luma_bottom_left, want.luma_bl);
                check_field("luma_bottom_right", o_luma_bottom_right, want.luma_br);
                check_field("chroma_blue", o_chroma_blue, want.chroma_b);
                check_field("chroma_red", o_chroma_red, want.chroma_r);
            end
            results_seen++;
        end
    end

    // receiver: long hold-off, random stall runs, or always ready
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (stall_run > 0) begin
                i_stall <= 1'b1;
                stall_run--;
            end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
                i_stall <= 1'b1;
                stall_run = pick_gap() - 1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // sender idles for a random stretch now and then
    task automatic sender_gap();
        if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
    endtask

    // offer one quad and hold it until accepted; called just after a rising edge
    task automatic send_quad(input t_rgb_quad q);
        i_valid              <= 1'b1;
        i_top_left_red       <= q[0].red;
        i_top_left_green     <= q[0].green;
        i_top_left_blue      <= q[0].blue;
        i_top_right_red      <= q[1].red;
        i_top_right_green    <= q[1].green;
        i_top_right_blue     <= q[1].blue;
        i_bottom_left_red    <= q[2].red;
        i_bottom_left_green  <= q[2].green;
        i_bottom_left_blue   <= q[2].blue;
        i_bottom_right_red   <= q[3].red;
        i_bottom_right_green <= q[3].green;
        i_bottom_right_blue  <= q[3].blue;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_ycc.push_back(convert_quad(q, model_height));
        sender_gap();
    endtask

    // stop offering and wait until every expected item is out, then let it settle
    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (pending_ycc.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // frame height write, only with the pipeline empty
    task automatic write_height(input logic [11:0] height);
        wait_for_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= height;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        model_height = height;
        @(posedge i_clk);
    endtask

    // primaries, secondaries and extremes at the reset height
    task automatic test_directed();
        rycq_pkg::t_pixel black, white, red, green, blue;
        black = make_px(0, 0, 0);
        white = make_px(255, 255, 255);
        red   = make_px(255, 0, 0);
        green = make_px(0, 255, 0);
        blue  = make_px(0, 0, 255);
        gap_pct   = 30;
        stall_pct = 30;
        send_quad(flat_quad(black));
        send_quad(flat_quad(white));
        send_quad(flat_quad(red));
        send_quad(flat_quad(green));
        send_quad(flat_quad(blue));
        send_quad({red, green, blue, white});
        send_quad({make_px(0, 255, 255), make_px(255, 0, 255), make_px(255, 255, 0), black});
        send_quad({make_px(170, 85, 170), make_px(85, 170, 85),
                   make_px(170, 85, 170), make_px(85, 170, 85)});
        send_quad({white, black, black, black});
        send_quad({black, black, black, white});
    endtask

    // matrix choice on both sides of the 576 line boundary and at the register ends
    task automatic test_matrix_select();
        logic [11:0] heights [4];
        int          i;
        heights = '{12'd576, 12'd577, 12'd0, 12'd4095};
        for (i = 0; i < 4; i++) begin
            write_height(heights[i]);
            send_quad(flat_quad(make_px(255, 0, 0)));
            send_quad({make_px(255, 0, 0), make_px(0, 255, 0), make_px(0, 0, 255),
                       make_px(255, 255, 255)});
            send_quad({make_px(0, 255, 255), make_px(255, 0, 255), make_px(255, 255, 0),
                       make_px(0, 0, 0)});
        end
    endtask

    // random quads at one height with idling on both sides
    task automatic test_random_height(input logic [11:0] height, input int count,
                                      input int gaps, input int stalls);
        write_height(height);
        gap_pct   = gaps;
        stall_pct = stalls;
        repeat (count) send_quad(random_quad());
    endtask

    // back to back with the receiver always ready
    task automatic test_full_rate(input int count);
        write_height(HEIGHT_AT_RESET);
        gap_pct   = 0;
        stall_pct = 0;
        repeat (count) send_quad(random_quad());
    endtask

    // receiver holds off while quads keep coming, so the pipe fills and stalls its input
    task automatic test_backpressure();
        write_height(12'($urandom_range(1, 575)));
        gap_pct   = 0;
        stall_pct = 0;
        hold_left = 150;
        repeat (40) send_quad(random_quad());
        wait_for_results();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_matrix_select();
        test_random_height(12'($urandom_range(1, 575)), 160, 30, 30);
        test_random_height(12'($urandom_range(578, 4094)), 160, 10, 50);
        test_random_height(12'd576, 160, 50, 10);
        test_random_height(12'd577, 160, 30, 30);
        test_random_height(12'd0, 160, 20, 20);
        test_random_height(12'd4095, 160, 40, 40);
        test_full_rate(130);
        test_backpressure();

        stall_pct = 0;
        wait_for_results();
        if (mismatch_count == 0 && pending_ycc.size() == 0) begin
            $display("PASS rgb_to_ycbcr420_quad");
        end else begin
            $display("FAIL rgb_to_ycbcr420_quad");
        end
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("FAIL rgb_to_ycbcr420_quad");
        $finish;
    end

endmodule

// ----- rgb_to_ycbcr420_quad.f -----
+incdir+rtl
rtl/rycq_pkg.sv
rtl/rycq_lane.sv
rtl/rycq_merge.sv
rtl/rgb_to_ycbcr420_quad.sv
rtl/rycq_checker.sv
tb/rgb_to_ycbcr420_quad_tb.sv
